// File: hw/rtl/blpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_pkg: shared types and constants for the Bresenham line generator
// Coordinate, color and bus widths, screen size, line point struct, command codes.
// ----------------------------------------------------------------------------
package blpg_pkg;

  localparam int COORD_W       = 16;
  localparam int ERR_W         = 18;
  localparam int COLOR_W       = 8;
  localparam int ADDR_W        = 20;
  localparam int IN_DATA_W     = 88;
  localparam int OUT_DATA_W    = 80;
  localparam int OUT_USER_W    = 2;
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 1024;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic                      emitted;
    logic                      last;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } point_t;

endpackage

// File: hw/rtl/bresenham_line_pixel_generator_core.sv
`timescale 1ns / 1ps
// Path: each input beat passes the step register, then the clip/address register.
// Throughput: one beat per cycle unless out_tready stalls; a step updates err and the point.
// The y*width product sits in the second stage.
// Reset: synchronous active-low rst_n clears the line state and both valid flags.
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_core: Bresenham line rasterizer top level
// Start beat loads a line and gives its first point; step beats walk it.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_core #(
  parameter int SCREEN_WIDTH  = blpg_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = blpg_pkg::SCREEN_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_x[15:0] start_y[31:16] end_x[47:32] end_y[63:48]
  // red[71:64] green[79:72] blue[87:80]
  input  logic [blpg_pkg::IN_DATA_W-1:0]     in_tdata,
  // command[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // point_x[15:0] point_y[31:16] pixel_address[51:32]
  // out_red[59:52] out_green[67:60] out_blue[75:68] zero[79:76]
  output logic [blpg_pkg::OUT_DATA_W-1:0]    out_tdata,
  // emitted[0] on_screen[1]
  output logic [blpg_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                               out_tlast
);

  logic             in_acc;
  logic             s1_valid;
  logic             s2_free;
  logic             s2_load;
  blpg_pkg::point_t pt;

  assign s2_free   = !out_tvalid || out_tready;
  assign s2_load   = s1_valid && s2_free;
  assign in_tready = !s1_valid || s2_free;
  assign in_acc    = in_tvalid && in_tready;

  blpg_stepper u_stepper (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_acc),
    .drain    (s2_load),
    .command  (in_tuser),
    .start_x  (in_tdata[15:0]),
    .start_y  (in_tdata[31:16]),
    .end_x    (in_tdata[47:32]),
    .end_y    (in_tdata[63:48]),
    .red      (in_tdata[71:64]),
    .green    (in_tdata[79:72]),
    .blue     (in_tdata[87:80]),
    .pt_valid (s1_valid),
    .pt       (pt)
  );

  blpg_pixel_out #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_pixel_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s2_load),
    .out_tready (out_tready),
    .pt         (pt),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_onscreen_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("on_screen without emitted point");

  a_last_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("last on empty result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == '0))
    else $error("empty result carries data");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid)
    else $error("accepted beat lost in step stage");

endmodule

// File: hw/rtl/blpg_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_stepper: line state and Bresenham step
// Holds the line state, runs start/step per beat and registers the point.
// ----------------------------------------------------------------------------
module blpg_stepper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic                                drain,
  input  logic                                command,
  input  logic signed [blpg_pkg::COORD_W-1:0] start_x,
  input  logic signed [blpg_pkg::COORD_W-1:0] start_y,
  input  logic signed [blpg_pkg::COORD_W-1:0] end_x,
  input  logic signed [blpg_pkg::COORD_W-1:0] end_y,
  input  logic [blpg_pkg::COLOR_W-1:0]        red,
  input  logic [blpg_pkg::COLOR_W-1:0]        green,
  input  logic [blpg_pkg::COLOR_W-1:0]        blue,
  output logic                                pt_valid,
  output blpg_pkg::point_t                    pt
);

  localparam int CW = blpg_pkg::COORD_W;
  localparam int EW = blpg_pkg::ERR_W;
  localparam int KW = blpg_pkg::COLOR_W;

  logic                 active_r, active_nxt;
  logic signed [CW-1:0] cur_x_r, cur_x_nxt;
  logic signed [CW-1:0] cur_y_r, cur_y_nxt;
  logic signed [CW-1:0] tgt_x_r, tgt_x_nxt;
  logic signed [CW-1:0] tgt_y_r, tgt_y_nxt;
  logic [CW-1:0]        adx_r, adx_nxt;
  logic [CW-1:0]        ady_r, ady_nxt;
  logic                 sxn_r, sxn_nxt;
  logic                 syn_r, syn_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [KW-1:0]        red_r, red_nxt;
  logic [KW-1:0]        grn_r, grn_nxt;
  logic [KW-1:0]        blu_r, blu_nxt;
  logic                 pt_valid_r, pt_valid_nxt;
  blpg_pkg::point_t     pt_r, pt_nxt;

  logic signed [CW:0]   ddx, ddy;
  logic signed [EW:0]   e2, err_w;
  logic                 mv_x, mv_y, fin;

  always_comb begin
    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    adx_nxt    = adx_r;
    ady_nxt    = ady_r;
    sxn_nxt    = sxn_r;
    syn_nxt    = syn_r;
    err_nxt    = err_r;
    red_nxt    = red_r;
    grn_nxt    = grn_r;
    blu_nxt    = blu_r;
    pt_nxt     = '0;
    fin        = 1'b0;
    ddx        = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    ddy        = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    e2         = {err_r, 1'b0};
    mv_x       = e2 > -$signed({{(EW-CW+1){1'b0}}, ady_r});
    mv_y       = e2 < $signed({{(EW-CW+1){1'b0}}, adx_r});
    err_w      = {err_r[EW-1], err_r}
                 - (mv_x ? $signed({{(EW-CW+1){1'b0}}, ady_r}) : '0)
                 + (mv_y ? $signed({{(EW-CW+1){1'b0}}, adx_r}) : '0);
    if (command == blpg_pkg::CMD_START) begin
      adx_nxt   = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
      ady_nxt   = ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
      sxn_nxt   = !(start_x < end_x);
      syn_nxt   = !(start_y < end_y);
      err_nxt   = $signed({2'b00, adx_nxt}) - $signed({2'b00, ady_nxt});
      cur_x_nxt = start_x;
      cur_y_nxt = start_y;
      tgt_x_nxt = end_x;
      tgt_y_nxt = end_y;
      red_nxt   = red;
      grn_nxt   = green;
      blu_nxt   = blue;
      fin       = (start_x == end_x) && (start_y == end_y);
      active_nxt = !fin;
    end else if (active_r) begin
      err_nxt   = err_w[EW-1:0];
      if (mv_x) begin
        cur_x_nxt = sxn_r ? cur_x_r - CW'(1) : cur_x_r + CW'(1);
      end
      if (mv_y) begin
        cur_y_nxt = syn_r ? cur_y_r - CW'(1) : cur_y_r + CW'(1);
      end
      fin = (cur_x_nxt == tgt_x_r) && (cur_y_nxt == tgt_y_r);
      if (fin) begin
        active_nxt = 1'b0;
      end
    end
    if ((command == blpg_pkg::CMD_START) || active_r) begin
      pt_nxt.emitted = 1'b1;
      pt_nxt.last    = fin;
      pt_nxt.x       = cur_x_nxt;
      pt_nxt.y       = cur_y_nxt;
      pt_nxt.red     = red_nxt;
      pt_nxt.green   = grn_nxt;
      pt_nxt.blue    = blu_nxt;
    end
  end

  always_comb begin
    pt_valid_nxt = pt_valid_r;
    if (load) begin
      pt_valid_nxt = 1'b1;
    end else if (drain) begin
      pt_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      tgt_x_r    <= '0;
      tgt_y_r    <= '0;
      adx_r      <= '0;
      ady_r      <= '0;
      sxn_r      <= 1'b0;
      syn_r      <= 1'b0;
      err_r      <= '0;
      red_r      <= '0;
      grn_r      <= '0;
      blu_r      <= '0;
      pt_valid_r <= 1'b0;
    end else begin
      pt_valid_r <= pt_valid_nxt;
      if (load) begin
        active_r <= active_nxt;
        cur_x_r  <= cur_x_nxt;
        cur_y_r  <= cur_y_nxt;
        tgt_x_r  <= tgt_x_nxt;
        tgt_y_r  <= tgt_y_nxt;
        adx_r    <= adx_nxt;
        ady_r    <= ady_nxt;
        sxn_r    <= sxn_nxt;
        syn_r    <= syn_nxt;
        err_r    <= err_nxt;
        red_r    <= red_nxt;
        grn_r    <= grn_nxt;
        blu_r    <= blu_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pt_r <= pt_nxt;
    end
  end

  assign pt_valid = pt_valid_r;
  assign pt       = pt_r;

endmodule

// File: hw/rtl/blpg_pixel_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_pixel_out: screen clip, framebuffer address and result register
// Flags on-screen points, forms y*width+x and holds the output beat.
// ----------------------------------------------------------------------------
module blpg_pixel_out #(
  parameter int SCREEN_WIDTH  = blpg_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = blpg_pkg::SCREEN_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic                                 out_tready,
  input  blpg_pkg::point_t                     pt,
  output logic                                 out_tvalid,
  output logic [blpg_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [blpg_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast
);

  localparam int CW = blpg_pkg::COORD_W;
  localparam int AW = blpg_pkg::ADDR_W;

  logic                               valid_r, valid_nxt;
  logic [blpg_pkg::OUT_DATA_W-1:0]    data_r, data_nxt;
  logic [blpg_pkg::OUT_USER_W-1:0]    user_r, user_nxt;
  logic                               last_r, last_nxt;
  logic                               on;
  logic [2*CW-1:0]                    prod;
  logic [AW-1:0]                      addr;

  always_comb begin
    on   = pt.emitted && !pt.x[CW-1] && !pt.y[CW-1]
           && (pt.x < $signed(CW'(SCREEN_WIDTH)))
           && (pt.y < $signed(CW'(SCREEN_HEIGHT)));
    prod = pt.y * CW'(SCREEN_WIDTH);
    addr = on ? AW'(prod + {{CW{1'b0}}, pt.x}) : '0;
    data_nxt = {4'd0, pt.blue, pt.green, pt.red, addr, pt.y, pt.x};
    user_nxt = {on, pt.emitted};
    last_nxt = pt.last;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// File: bench/bresenham_line_pixel_generator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_core_test: line rasterizer self-checking bench
// Drives start and step beats (a directed table, then random lines, mostly short and
// near the screen edges, full-range lines and stray steps), predicts points with a
// behavioral Bresenham walker or typed rows, checking each result beat field by field
// under several mixes of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_core_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BEATS    = 450;

  typedef struct packed {
    logic        emitted;
    logic        on_screen;
    logic [15:0] x;
    logic [15:0] y;
    logic [19:0] addr;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } pixel_t;

  typedef struct {
    logic                           cmd;
    logic [blpg_pkg::IN_DATA_W-1:0] data;
    bit                             typed;
    pixel_t                         want;
  } beat_note_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [blpg_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [blpg_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [blpg_pkg::OUT_USER_W-1:0] out_tuser;
  logic                            out_tlast;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int mismatches  = 0;
  int idle_cycles = 0;
  int beats_sent  = 0;

  pixel_t     pending_pixels[$];
  beat_note_t beat_notes[$];
  beat_note_t dir_rows[$];

  // walker state
  logic        ln_active = 1'b0;
  int          cur_x = 0, cur_y = 0, tgt_x = 0, tgt_y = 0;
  int          adx = 0, ady = 0, err = 0;
  logic        neg_x = 1'b0, neg_y = 1'b0;
  logic [23:0] color = '0;

  bresenham_line_pixel_generator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic [blpg_pkg::IN_DATA_W-1:0] pack_line(input int sx, input int sy,
                                                               input int ex, input int ey,
                                                               input logic [23:0] rgb);
    logic [15:0] a, b, c, d;
    a = sx[15:0];
    b = sy[15:0];
    c = ex[15:0];
    d = ey[15:0];
    return {rgb[7:0], rgb[15:8], rgb[23:16], d, c, b, a};
  endfunction

  function automatic pixel_t point_at(input bit fin);
    pixel_t p;
    p.emitted   = 1'b1;
    p.on_screen = cur_x >= 0 && cur_x < blpg_pkg::SCREEN_WIDTH &&
                  cur_y >= 0 && cur_y < blpg_pkg::SCREEN_HEIGHT;
    p.x         = cur_x[15:0];
    p.y         = cur_y[15:0];
    p.addr      = p.on_screen ? 20'(cur_y * blpg_pkg::SCREEN_WIDTH + cur_x) : '0;
    p.red       = color[23:16];
    p.green     = color[15:8];
    p.blue      = color[7:0];
    p.last      = fin;
    return p;
  endfunction

  task automatic trace_line(input logic cmd, input logic [blpg_pkg::IN_DATA_W-1:0] d,
                            output pixel_t p);
    int x1, y1, x2, y2, e2;
    bit fin;
    p = '0;
    if (cmd == blpg_pkg::CMD_START) begin
      x1    = $signed(d[15:0]);
      y1    = $signed(d[31:16]);
      x2    = $signed(d[47:32]);
      y2    = $signed(d[63:48]);
      adx   = (x2 > x1) ? x2 - x1 : x1 - x2;
      ady   = (y2 > y1) ? y2 - y1 : y1 - y2;
      neg_x = !(x1 < x2);
      neg_y = !(y1 < y2);
      err   = adx - ady;
      cur_x = x1;
      cur_y = y1;
      tgt_x = x2;
      tgt_y = y2;
      color = {d[71:64], d[79:72], d[87:80]};
      fin   = (x1 == x2) && (y1 == y2);
      ln_active = !fin;
      p = point_at(fin);
    end else if (ln_active) begin
      e2 = 2 * err;
      if (e2 > -ady) begin
        err   = err - ady;
        cur_x = cur_x + (neg_x ? -1 : 1);
      end
      if (e2 < adx) begin
        err   = err + adx;
        cur_y = cur_y + (neg_y ? -1 : 1);
      end
      fin = (cur_x == tgt_x) && (cur_y == tgt_y);
      if (fin) ln_active = 1'b0;
      p = point_at(fin);
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // result check first, then prediction of the beat accepted at the same edge
  always @(posedge clk) begin
    pixel_t     want;
    pixel_t     predicted;
    beat_note_t note;
    bit         moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (pending_pixels.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat, tdata %h", out_tdata));
        end else begin
          want = pending_pixels.pop_front();
          check_field("emitted", 32'(out_tuser[0]), 32'(want.emitted));
          check_field("on_screen", 32'(out_tuser[1]), 32'(want.on_screen));
          check_field("point_x", 32'(out_tdata[15:0]), 32'(want.x));
          check_field("point_y", 32'(out_tdata[31:16]), 32'(want.y));
          check_field("pixel_address", 32'(out_tdata[51:32]), 32'(want.addr));
          check_field("out_red", 32'(out_tdata[59:52]), 32'(want.red));
          check_field("out_green", 32'(out_tdata[67:60]), 32'(want.green));
          check_field("out_blue", 32'(out_tdata[75:68]), 32'(want.blue));
          check_field("last", 32'(out_tlast), 32'(want.last));
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        note  = beat_notes.pop_front();
        trace_line(in_tuser, in_tdata, predicted);
        pending_pixels.push_back(note.typed ? note.want : predicted);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [blpg_pkg::IN_DATA_W-1:0] data,
                           input bit typed = 1'b0, input pixel_t want = '0);
    beat_note_t note;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    note.cmd   = cmd;
    note.data  = data;
    note.typed = typed;
    note.want  = want;
    beat_notes.push_back(note);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic add_row(input logic cmd, input int sx, input int sy, input int ex,
                         input int ey, input logic [23:0] rgb,
                         input bit typed = 1'b0, input pixel_t want = '0);
    beat_note_t r;
    r.cmd   = cmd;
    r.data  = pack_line(sx, sy, ex, ey, rgb);
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  function automatic int clamp16(input int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1023;
      2: return 1024;
      3: return -1;
      4: return $urandom_range(1000, 1100);
      5: return int'($urandom_range(0, 80)) - 40;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  function automatic int rand_delta();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 400)) - 200;
    return int'($urandom_range(0, 24)) - 12;
  endfunction

  function automatic logic [blpg_pkg::IN_DATA_W-1:0] rand_data();
    return pack_line($urandom, $urandom, $urandom, $urandom, 24'($urandom));
  endfunction

  task automatic random_segment();
    int x1, y1, x2, y2, n, steps, kind, r;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // full-range endpoints: walk a few points, next start drops the line
      x1 = int'($urandom_range(0, 65535)) - 32768;
      y1 = int'($urandom_range(0, 65535)) - 32768;
      x2 = int'($urandom_range(0, 65535)) - 32768;
      y2 = int'($urandom_range(0, 65535)) - 32768;
      send_beat(blpg_pkg::CMD_START, pack_line(x1, y1, x2, y2, 24'($urandom)));
      steps = $urandom_range(0, 4);
    end else if (kind < 14) begin
      steps = $urandom_range(1, 3);
    end else begin
      x1 = clamp16(edge_coord());
      y1 = clamp16(edge_coord());
      x2 = clamp16(x1 + rand_delta());
      y2 = clamp16(y1 + rand_delta());
      send_beat(blpg_pkg::CMD_START, pack_line(x1, y1, x2, y2, 24'($urandom)));
      n = (x2 > x1 ? x2 - x1 : x1 - x2);
      if ((y2 > y1 ? y2 - y1 : y1 - y2) > n) n = (y2 > y1 ? y2 - y1 : y1 - y2);
      r = $urandom_range(0, 99);
      steps = (r < 12) ? $urandom_range(0, n) : (r < 24) ? n + $urandom_range(1, 3) : n;
    end
    repeat (steps) send_beat(blpg_pkg::CMD_STEP, rand_data());
  endtask

  initial begin
    int phase_end;
    // directed table: typed rows hold values readable without walking the line
    add_row(blpg_pkg::CMD_STEP, 0, 0, 0, 0, 24'h0, 1'b1, '0);
    add_row(blpg_pkg::CMD_START, 0, 0, 0, 0, 24'hff00aa, 1'b1,
            '{1'b1, 1'b1, 16'h0, 16'h0, 20'h0, 8'hff, 8'h00, 8'haa, 1'b1});
    add_row(blpg_pkg::CMD_STEP, 0, 0, 0, 0, 24'h0, 1'b1, '0);
    add_row(blpg_pkg::CMD_START, 1023, 1023, 1023, 1023, 24'h00ff55, 1'b1,
            '{1'b1, 1'b1, 16'd1023, 16'd1023, 20'hfffff, 8'h00, 8'hff, 8'h55, 1'b1});
    add_row(blpg_pkg::CMD_START, -32768, -32768, -32768, -32768, 24'h123456, 1'b1,
            '{1'b1, 1'b0, 16'h8000, 16'h8000, 20'h0, 8'h12, 8'h34, 8'h56, 1'b1});
    add_row(blpg_pkg::CMD_START, 32767, 32767, 32767, 32767, 24'h8001fe, 1'b1,
            '{1'b1, 1'b0, 16'h7fff, 16'h7fff, 20'h0, 8'h80, 8'h01, 8'hfe, 1'b1});
    add_row(blpg_pkg::CMD_START, 1024, 0, 1024, 0, 24'h010204, 1'b1,
            '{1'b1, 1'b0, 16'd1024, 16'h0, 20'h0, 8'h01, 8'h02, 8'h04, 1'b1});
    add_row(blpg_pkg::CMD_START, 0, 1024, 0, 1024, 24'h081020, 1'b1,
            '{1'b1, 1'b0, 16'h0, 16'd1024, 20'h0, 8'h08, 8'h10, 8'h20, 1'b1});
    add_row(blpg_pkg::CMD_START, -1, 5, -1, 5, 24'h4080c0, 1'b1,
            '{1'b1, 1'b0, 16'hffff, 16'd5, 20'h0, 8'h40, 8'h80, 8'hc0, 1'b1});
    add_row(blpg_pkg::CMD_START, -32768, -32768, 32767, 32767, 24'hffffff);
    add_row(blpg_pkg::CMD_STEP, 0, 0, 0, 0, 24'h0);
    add_row(blpg_pkg::CMD_STEP, 0, 0, 0, 0, 24'h0);
    add_row(blpg_pkg::CMD_START, 32767, -32768, -32768, 32767, 24'h55aa0f);
    add_row(blpg_pkg::CMD_STEP, 0, 0, 0, 0, 24'h0);
    add_row(blpg_pkg::CMD_START, 0, 0, 3, 1, 24'h7f80c3);
    repeat (3) add_row(blpg_pkg::CMD_STEP, 0, 0, 0, 0, 24'h0);
    add_row(blpg_pkg::CMD_STEP, 0, 0, 0, 0, 24'h0, 1'b1, '0);
    add_row(blpg_pkg::CMD_START, 1021, 1022, 1025, 1018, 24'hc0ffee);
    repeat (4) add_row(blpg_pkg::CMD_STEP, 0, 0, 0, 0, 24'h0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) random_segment();
      drain();
    end

    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/blpg_pkg.sv
hw/rtl/blpg_stepper.sv
hw/rtl/blpg_pixel_out.sv
hw/rtl/bresenham_line_pixel_generator_core.sv
bench/bresenham_line_pixel_generator_core_test.sv
